// ===== rtl/core/tfn_pkg.sv =====
package tfn_pkg;

	localparam int VERTEX_DEPTH_DEF = 4096;

	// request codes
	localparam logic [1:0] REQ_CLEAR  = 2'd0;
	localparam logic [1:0] REQ_APPEND = 2'd1;
	localparam logic [1:0] REQ_ROW    = 2'd2;
	localparam logic [1:0] REQ_TRI    = 2'd3;

	// result kinds
	localparam logic [1:0] KIND_CORNER = 2'd0;
	localparam logic [1:0] KIND_NORMAL = 2'd1;
	localparam logic [1:0] KIND_ERROR  = 2'd2;

	// error codes
	localparam logic [1:0] ERR_NONE  = 2'd0;
	localparam logic [1:0] ERR_INDEX = 2'd1;
	localparam logic [1:0] ERR_FULL  = 2'd2;

	// sum of squares width and root / quotient width
	localparam int RAD_W  = 62;
	localparam int ROOT_W = 31;

	// travels with each product through the multiplier
	typedef struct packed {
		logic       first;  // restart the accumulator
		logic       last;   // final term of one sum
		logic       fin;    // final term of the whole pass
		logic       neg;    // subtract the product
		logic       rnd;    // start from the rounding half
		logic [1:0] dst;    // component the sum belongs to
	} mul_tag_t;

	typedef struct packed {
		logic start;
		logic sqrt;         // 1: square root, 0: divide
	} dsq_cmd_t;

endpackage

// ===== rtl/core/triangle_transform_face_normal_unit.sv =====
// Affine vertex transform with unit face normal, signed Q16.16. Words on the
// input side clear the vertex store, append a vertex, load one row of the 4x3
// row-vector matrix (rows 0..2 linear, row 3 translation; reset is identity),
// or submit a triangle as three store indices. A triangle whose indices are all
// below the vertex count returns four result words: the three transformed,
// saturated corners (last low) and then the unit normal of the corner edges
// (last high), zero for a degenerate triangle. A bad index or an append to a
// full store returns one error word instead. Clear, append and row loads
// leave in_ready high. A triangle is handled one item at a time, with
// in_ready low meanwhile, and output stalls lengthen it: each corner is a
// store read and 12 passes through the one 32x32 registered multiplier, the
// cross product and sum of squares reuse it, the normalizing shift moves one
// bit per cycle, and the shared bit-serial unit spends 31 steps on the square
// root and 17 on each of the three divides, each begun from a start state. A
// finished word waits in the output register while the next input word is
// taken.
module triangle_transform_face_normal_unit import tfn_pkg::*; #(
	parameter int VERTEX_DEPTH = VERTEX_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         req_type,
	input  logic [1:0]         row_index,
	input  logic signed [31:0] val_x,
	input  logic signed [31:0] val_y,
	input  logic signed [31:0] val_z,
	input  logic [15:0]        corner_a,
	input  logic [15:0]        corner_b,
	input  logic [15:0]        corner_c,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         result_kind,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [31:0] out_z,
	output logic [1:0]         error_code,
	output logic               last
);

	localparam int AW    = $clog2(VERTEX_DEPTH);
	localparam int CW    = $clog2(VERTEX_DEPTH + 1);
	localparam int ACC_W = 66;

	localparam logic signed [31:0]      Q_ONE  = 32'sd65536;
	localparam logic signed [ACC_W-1:0] RND    = ACC_W'(32768);
	localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(64'sh0000_0000_7FFF_FFFF);
	localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-64'sh0000_0000_8000_0000);

	// sequencer states
	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_RDWAIT  = 4'd1;
	localparam logic [3:0] S_XF      = 4'd2;
	localparam logic [3:0] S_XOUT    = 4'd3;
	localparam logic [3:0] S_EDGE    = 4'd4;
	localparam logic [3:0] S_CROSS   = 4'd5;
	localparam logic [3:0] S_NORM    = 4'd6;
	localparam logic [3:0] S_SQ      = 4'd7;
	localparam logic [3:0] S_SQRT_GO = 4'd8;
	localparam logic [3:0] S_SQRT    = 4'd9;
	localparam logic [3:0] S_DIV_GO  = 4'd10;
	localparam logic [3:0] S_DIV     = 4'd11;
	localparam logic [3:0] S_NOUT    = 4'd12;
	localparam logic [3:0] S_ERR     = 4'd13;

	logic [3:0]  state_q;
	logic [CW-1:0] count_q;
	logic signed [31:0] mat_q [12];
	logic [1:0]  cnt_q;
	logic [3:0]  st_q;
	logic        ov_q;

	logic [15:0] idx_q [3];
	logic [1:0]  err_q;
	logic signed [31:0] corner_q [3][3];
	logic signed [31:0] e1_q [3];
	logic signed [31:0] e2_q [3];
	logic [RAD_W-1:0] xmag_q [3];
	logic        xneg_q [3];
	logic [RAD_W-1:0] sum_q;
	logic [ROOT_W-1:0] len_q;
	logic signed [31:0] nrm_q [3];
	logic signed [ACC_W-1:0] acc_q;

	logic [1:0]  kind_q;
	logic signed [31:0] ox_q, oy_q, oz_q;
	logic [1:0]  code_q;
	logic        last_q;

	// ---- input decode ----
	logic accept;
	logic full;
	logic bad_idx;
	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign full     = (count_q == CW'(VERTEX_DEPTH));
	assign bad_idx  = ({1'b0, corner_a} >= 17'(count_q)) ||
	                  ({1'b0, corner_b} >= 17'(count_q)) ||
	                  ({1'b0, corner_c} >= 17'(count_q));

	// ---- vertex store ----
	logic        vs_wr;
	logic [95:0] vs_rd;
	logic signed [31:0] vtx [3];
	assign vs_wr = accept && (req_type == REQ_APPEND) && !full;

	tfn_vstore #(.DEPTH(VERTEX_DEPTH)) u_vstore (
		.clk     (clk),
		.wr_en   (vs_wr),
		.wr_addr (count_q[AW-1:0]),
		.wr_data ({val_z, val_y, val_x}),
		.rd_addr (idx_q[cnt_q][AW-1:0]),
		.rd_data (vs_rd)
	);

	assign vtx[0] = vs_rd[31:0];
	assign vtx[1] = vs_rd[63:32];
	assign vtx[2] = vs_rd[95:64];

	// ---- shared multiplier: operand select ----
	logic               mul_go;
	logic signed [31:0] mul_a, mul_b;
	mul_tag_t           mul_tag;
	logic               mul_vld;
	logic signed [63:0] mul_prod;
	mul_tag_t           mul_otag;
	logic [1:0] kk, jj, cm, ia, la;
	logic [3:0] midx;

	always_comb begin
		mul_go  = 1'b0;
		mul_a   = '0;
		mul_b   = '0;
		mul_tag = '0;
		kk      = st_q[1:0];
		jj      = st_q[3:2];
		cm      = st_q[2:1];
		midx    = 4'({2'b00, kk} * 4'd3 + {2'b00, jj});
		case (cm)
			2'd0: begin ia = 2'd1; la = 2'd2; end
			2'd1: begin ia = 2'd2; la = 2'd0; end
			default: begin ia = 2'd0; la = 2'd1; end
		endcase
		case (state_q)
			S_XF: begin
				// corner component j = sum over k of v[k] * M[k][j], plus 1.0 * M[3][j]
				if (st_q < 4'd12) begin
					mul_go = 1'b1;
					case (kk)
						2'd0: mul_a = vtx[0];
						2'd1: mul_a = vtx[1];
						2'd2: mul_a = vtx[2];
						default: mul_a = Q_ONE;
					endcase
					mul_b         = mat_q[midx];
					mul_tag.first = (kk == 2'd0);
					mul_tag.last  = (kk == 2'd3);
					mul_tag.fin   = (st_q == 4'd11);
					mul_tag.rnd   = 1'b1;
					mul_tag.dst   = jj;
				end
			end
			S_CROSS: begin
				if (st_q < 4'd6) begin
					mul_go        = 1'b1;
					mul_a         = st_q[0] ? e1_q[la] : e1_q[ia];
					mul_b         = st_q[0] ? e2_q[ia] : e2_q[la];
					mul_tag.first = !st_q[0];
					mul_tag.last  = st_q[0];
					mul_tag.neg   = st_q[0];
					mul_tag.fin   = (st_q == 4'd5);
					mul_tag.dst   = cm;
				end
			end
			S_SQ: begin
				if (st_q < 4'd3) begin
					mul_go        = 1'b1;
					mul_a         = 32'(xmag_q[st_q[1:0]][29:0]);
					mul_b         = 32'(xmag_q[st_q[1:0]][29:0]);
					mul_tag.first = (st_q == 4'd0);
					mul_tag.last  = (st_q == 4'd2);
					mul_tag.fin   = (st_q == 4'd2);
					mul_tag.dst   = st_q[1:0];
				end
			end
			default: begin
			end
		endcase
	end

	tfn_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (mul_go),
		.a       (mul_a),
		.b       (mul_b),
		.tag     (mul_go ? mul_tag : '0),
		.out_vld (mul_vld),
		.prod    (mul_prod),
		.out_tag (mul_otag)
	);

	// ---- accumulator ----
	logic signed [ACC_W-1:0] pe, acc_next, acc_sh, acc_mag;
	logic signed [31:0] sat_val;
	always_comb begin
		pe       = ACC_W'(mul_prod);
		acc_next = (mul_otag.first ? (mul_otag.rnd ? RND : '0) : acc_q) +
		           (mul_otag.neg ? -pe : pe);
		acc_sh   = acc_next >>> 16;
		if (acc_sh > SAT_HI) begin
			sat_val = 32'sh7FFF_FFFF;
		end else if (acc_sh < SAT_LO) begin
			sat_val = -32'sh8000_0000;
		end else begin
			sat_val = acc_sh[31:0];
		end
		acc_mag = acc_next[ACC_W-1] ? -acc_next : acc_next;
	end

	// ---- edges, scaled below 2^30 ----
	logic signed [32:0] ed [6];
	logic [32:0] em [6];
	logic [32:0] eshm [6];
	logic signed [31:0] ee [6];
	logic big0, big1;
	always_comb begin
		big0 = 1'b0;
		big1 = 1'b0;
		for (int k = 0; k < 3; k++) begin
			ed[k]     = 33'(corner_q[1][k]) - 33'(corner_q[0][k]);
			ed[k + 3] = 33'(corner_q[2][k]) - 33'(corner_q[0][k]);
		end
		for (int k = 0; k < 6; k++) begin
			em[k] = ed[k][32] ? 33'(-ed[k]) : 33'(ed[k]);
			big0  = big0 | (|em[k][32:30]);
			big1  = big1 | (|em[k][32:31]);
		end
		for (int k = 0; k < 6; k++) begin
			eshm[k] = big1 ? (em[k] >> 2) : (big0 ? (em[k] >> 1) : em[k]);
			ee[k]   = ed[k][32] ? -32'(eshm[k]) : 32'(eshm[k]);
		end
	end

	// ---- cross product normalization flags ----
	logic any_hi, any_mid, any_nz;
	always_comb begin
		any_hi  = 1'b0;
		any_mid = 1'b0;
		any_nz  = 1'b0;
		for (int k = 0; k < 3; k++) begin
			any_hi  = any_hi  | (|xmag_q[k][RAD_W-1:30]);
			any_mid = any_mid | (|xmag_q[k][RAD_W-1:29]);
			any_nz  = any_nz  | (|xmag_q[k]);
		end
	end

	// ---- root / divide unit ----
	dsq_cmd_t          dsq_cmd;
	logic [RAD_W-1:0]  dsq_opa;
	logic              dsq_done;
	logic [ROOT_W-1:0] dsq_res;
	assign dsq_cmd.start = (state_q == S_SQRT_GO) || (state_q == S_DIV_GO);
	assign dsq_cmd.sqrt  = (state_q == S_SQRT_GO);
	// numerator |x| * 65536 + len / 2
	assign dsq_opa = (state_q == S_SQRT_GO) ? sum_q :
	                 (RAD_W'({xmag_q[cnt_q][29:0], 16'h0000}) + RAD_W'(len_q >> 1));

	tfn_dsq u_dsq (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (dsq_cmd),
		.opa    (dsq_opa),
		.opb    (len_q),
		.done   (dsq_done),
		.res    (dsq_res)
	);

	// ---- output slot ----
	logic slot_free, emit;
	assign slot_free = !ov_q || out_ready;
	assign emit = slot_free &&
	              ((state_q == S_XOUT) || (state_q == S_NOUT) || (state_q == S_ERR));

	// ---- sequencer and control state ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			cnt_q   <= '0;
			st_q    <= '0;
			ov_q    <= 1'b0;
			for (int i = 0; i < 12; i++) begin
				mat_q[i] <= (i == 0 || i == 4 || i == 8) ? Q_ONE : 32'sd0;
			end
		end else begin
			if (emit) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
			if (mul_go) begin
				st_q <= st_q + 4'd1;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (req_type)
							REQ_CLEAR: count_q <= '0;
							REQ_APPEND: begin
								if (full) begin
									state_q <= S_ERR;
								end else begin
									count_q <= count_q + CW'(1);
								end
							end
							REQ_ROW: begin
								mat_q[4'({2'b00, row_index} * 4'd3)]     <= val_x;
								mat_q[4'({2'b00, row_index} * 4'd3 + 4'd1)] <= val_y;
								mat_q[4'({2'b00, row_index} * 4'd3 + 4'd2)] <= val_z;
							end
							default: begin
								if (bad_idx) begin
									state_q <= S_ERR;
								end else begin
									cnt_q   <= '0;
									state_q <= S_RDWAIT;
								end
							end
						endcase
					end
				end
				S_RDWAIT: begin
					st_q    <= '0;
					state_q <= S_XF;
				end
				S_XF: begin
					if (mul_vld && mul_otag.fin) begin
						state_q <= S_XOUT;
					end
				end
				S_XOUT: begin
					if (slot_free) begin
						if (cnt_q == 2'd2) begin
							state_q <= S_EDGE;
						end else begin
							cnt_q   <= cnt_q + 2'd1;
							state_q <= S_RDWAIT;
						end
					end
				end
				S_EDGE: begin
					st_q    <= '0;
					state_q <= S_CROSS;
				end
				S_CROSS: begin
					if (mul_vld && mul_otag.fin) begin
						state_q <= S_NORM;
					end
				end
				S_NORM: begin
					if (!any_nz) begin
						state_q <= S_NOUT;
					end else if (!any_hi && any_mid) begin
						st_q    <= '0;
						state_q <= S_SQ;
					end
				end
				S_SQ: begin
					if (mul_vld && mul_otag.fin) begin
						state_q <= S_SQRT_GO;
					end
				end
				S_SQRT_GO: state_q <= S_SQRT;
				S_SQRT: begin
					if (dsq_done) begin
						cnt_q   <= '0;
						state_q <= S_DIV_GO;
					end
				end
				S_DIV_GO: state_q <= S_DIV;
				S_DIV: begin
					if (dsq_done) begin
						if (cnt_q == 2'd2) begin
							state_q <= S_NOUT;
						end else begin
							cnt_q   <= cnt_q + 2'd1;
							state_q <= S_DIV_GO;
						end
					end
				end
				S_NOUT: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				S_ERR: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// ---- datapath registers ----
	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q[0] <= corner_a;
			idx_q[1] <= corner_b;
			idx_q[2] <= corner_c;
			err_q    <= (req_type == REQ_APPEND) ? ERR_FULL : ERR_INDEX;
		end
		if (mul_vld) begin
			acc_q <= acc_next;
			if (mul_otag.last) begin
				case (state_q)
					S_XF: corner_q[cnt_q][mul_otag.dst] <= sat_val;
					S_CROSS: begin
						xmag_q[mul_otag.dst] <= acc_mag[RAD_W-1:0];
						xneg_q[mul_otag.dst] <= acc_next[ACC_W-1];
					end
					S_SQ: sum_q <= acc_next[RAD_W-1:0];
					default: begin
					end
				endcase
			end
		end
		if (state_q == S_EDGE) begin
			for (int k = 0; k < 3; k++) begin
				e1_q[k] <= ee[k];
				e2_q[k] <= ee[k + 3];
			end
		end
		// bring the largest cross magnitude into [2^29, 2^30), one bit a cycle; all zero gives a zero normal
		if (state_q == S_NORM) begin
			for (int k = 0; k < 3; k++) begin
				if (!any_nz) begin
					nrm_q[k] <= '0;
				end else if (any_hi) begin
					xmag_q[k] <= xmag_q[k] >> 1;
				end else if (!any_mid) begin
					xmag_q[k] <= xmag_q[k] << 1;
				end
			end
		end
		if (state_q == S_SQRT && dsq_done) begin
			len_q <= dsq_res;
		end
		if (state_q == S_DIV && dsq_done) begin
			nrm_q[cnt_q] <= xneg_q[cnt_q] ? -32'(dsq_res) : 32'(dsq_res);
		end
		if (emit) begin
			case (state_q)
				S_XOUT: begin
					kind_q <= KIND_CORNER;
					ox_q   <= corner_q[cnt_q][0];
					oy_q   <= corner_q[cnt_q][1];
					oz_q   <= corner_q[cnt_q][2];
					code_q <= ERR_NONE;
					last_q <= 1'b0;
				end
				S_NOUT: begin
					kind_q <= KIND_NORMAL;
					ox_q   <= nrm_q[0];
					oy_q   <= nrm_q[1];
					oz_q   <= nrm_q[2];
					code_q <= ERR_NONE;
					last_q <= 1'b1;
				end
				default: begin
					kind_q <= KIND_ERROR;
					ox_q   <= '0;
					oy_q   <= '0;
					oz_q   <= '0;
					code_q <= err_q;
					last_q <= 1'b1;
				end
			endcase
		end
	end

	assign out_valid   = ov_q;
	assign result_kind = kind_q;
	assign out_x       = ox_q;
	assign out_y       = oy_q;
	assign out_z       = oz_q;
	assign error_code  = code_q;
	assign last        = last_q;

	// ---- checks ----
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		18'(count_q) <= 18'(VERTEX_DEPTH))
		else $error("vertex count beyond store depth");

	a_mul_state: assert property (@(posedge clk) disable iff (!arst_n)
		mul_vld |-> (state_q == S_XF || state_q == S_CROSS || state_q == S_SQ))
		else $error("product returned outside a multiply pass");

	a_dsq_state: assert property (@(posedge clk) disable iff (!arst_n)
		dsq_done |-> (state_q == S_SQRT || state_q == S_DIV))
		else $error("root/divide finished while not awaited");

	a_corner_word: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && result_kind == KIND_CORNER) |-> (!last && error_code == ERR_NONE))
		else $error("corner word marked last or with error");

endmodule

// ===== rtl/core/tfn_vstore.sv =====
module tfn_vstore import tfn_pkg::*; #(
	parameter int DEPTH = VERTEX_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [$clog2(DEPTH)-1:0]   wr_addr,
	input  logic [95:0]                wr_data,
	input  logic [$clog2(DEPTH)-1:0]   rd_addr,
	output logic [95:0]                rd_data
);

	logic [95:0] mem_q [DEPTH];
	logic [95:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_q;

endmodule

// ===== rtl/core/tfn_mul.sv =====
module tfn_mul import tfn_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_vld,
	input  logic signed [31:0] a,
	input  logic signed [31:0] b,
	input  mul_tag_t           tag,
	output logic               out_vld,
	output logic signed [63:0] prod,
	output mul_tag_t           out_tag
);

	logic               vld_q;
	logic signed [63:0] prod_q;
	mul_tag_t           tag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= a * b;
		tag_q  <= tag;
	end

	assign out_vld = vld_q;
	assign prod    = prod_q;
	assign out_tag = tag_q;

endmodule

// ===== rtl/core/tfn_dsq.sv =====
// bit-serial square root / restoring divide, one compare-subtract per cycle
module tfn_dsq import tfn_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  dsq_cmd_t          cmd,
	input  logic [RAD_W-1:0]  opa,
	input  logic [ROOT_W-1:0] opb,
	output logic              done,
	output logic [ROOT_W-1:0] res
);

	localparam int SQRT_STEPS = RAD_W / 2;
	localparam int DIV_STEPS  = 17;
	localparam int DIV_SHIFT  = DIV_STEPS - 1;
	localparam int CNT_W      = $clog2(SQRT_STEPS);

	logic             busy_q;
	logic             done_q;
	logic             sqrt_q;
	logic [CNT_W-1:0] cnt_q;
	logic [RAD_W-1:0] rem_q;
	logic [RAD_W-1:0] rq_q;
	logic [RAD_W-1:0] bd_q;
	logic [RAD_W-1:0] trial;
	logic [RAD_W-1:0] diff;
	logic             take;

	assign trial = sqrt_q ? (rq_q + bd_q) : bd_q;
	assign take  = (rem_q >= trial);
	assign diff  = rem_q - trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			sqrt_q <= cmd.sqrt;
			rem_q  <= opa;
			rq_q   <= '0;
			if (cmd.sqrt) begin
				bd_q  <= RAD_W'(1) << (RAD_W - 2);
				cnt_q <= CNT_W'(SQRT_STEPS - 1);
			end else begin
				bd_q  <= RAD_W'(opb) << DIV_SHIFT;
				cnt_q <= CNT_W'(DIV_STEPS - 1);
			end
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (take) begin
				rem_q <= diff;
			end
			if (sqrt_q) begin
				rq_q <= take ? ((rq_q >> 1) + bd_q) : (rq_q >> 1);
				bd_q <= bd_q >> 2;
			end else begin
				rq_q <= {rq_q[RAD_W-2:0], take};
				bd_q <= bd_q >> 1;
			end
		end
	end

	assign done = done_q;
	assign res  = rq_q[ROOT_W-1:0];

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
	import tfn_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = VERTEX_DEPTH_DEF;
	localparam int IDLE_LIMIT = 20000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [1:0]         req_type = REQ_CLEAR;
	logic [1:0]         row_index = '0;
	logic signed [31:0] val_x = '0, val_y = '0, val_z = '0;
	logic [15:0]        corner_a = '0, corner_b = '0, corner_c = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [1:0]         result_kind;
	logic signed [31:0] out_x, out_y, out_z;
	logic [1:0]         error_code;
	logic               last;

	typedef struct {
		logic [1:0]         kind;
		logic signed [31:0] x, y, z;
		logic [1:0]         code;
		logic               fin;
	} res_word_t;

	// shadow of the block state
	logic signed [31:0] vtx_mem [DEPTH][3];
	int unsigned        vtx_count;
	logic signed [31:0] mtx [12];

	res_word_t pending_q [$];
	int        mismatches = 0;
	int        idle_cycles = 0;
	bit        burst_on = 1'b1;
	int        burst_left = 0;

	triangle_transform_face_normal_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.req_type(req_type), .row_index(row_index),
		.val_x(val_x), .val_y(val_y), .val_z(val_z),
		.corner_a(corner_a), .corner_b(corner_b), .corner_c(corner_c),
		.out_valid(out_valid), .out_ready(out_ready),
		.result_kind(result_kind), .out_x(out_x), .out_y(out_y), .out_z(out_z),
		.error_code(error_code), .last(last)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ---------------- predictor ----------------
	function automatic logic signed [31:0] sat32(logic signed [63:0] v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic longint shr_zero(longint v, int s);
		if (v < 0) return -((-v) >>> s);
		return v >>> s;
	endfunction

	function automatic longint unsigned mag(longint v);
		return (v < 0) ? longint'(-v) : longint'(v);
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else
				r = r >> 1;
			b = b >> 2;
		end
		return r;
	endfunction

	// exact sum of three Q32.32 products plus translation, rounded half up
	function automatic logic signed [31:0] xform_axis(int vi, int j);
		logic signed [95:0] acc;
		int k;
		acc = 96'(mtx[9+j]) <<< 16;
		for (k = 0; k < 3; k++)
			acc = acc + 96'(vtx_mem[vi][k]) * 96'(mtx[3*k+j]);
		acc = (acc + 96'sd32768) >>> 16;
		if (acc > 96'sd2147483647) return 32'sh7fffffff;
		if (acc < -96'sd2147483648) return 32'sh80000000;
		return acc[31:0];
	endfunction

	task automatic unit_normal(input logic signed [31:0] c [3][3],
			output logic signed [31:0] n [3]);
		longint e1 [3], e2 [3], cr [3];
		longint unsigned m, len, q;
		int s, k;
		m = 0;
		s = 0;
		for (k = 0; k < 3; k++) begin
			e1[k] = longint'(c[1][k]) - longint'(c[0][k]);
			e2[k] = longint'(c[2][k]) - longint'(c[0][k]);
			if (mag(e1[k]) > m) m = mag(e1[k]);
			if (mag(e2[k]) > m) m = mag(e2[k]);
		end
		while ((m >> s) >= (64'd1 << 30)) s++;
		for (k = 0; k < 3; k++) begin
			e1[k] = shr_zero(e1[k], s);
			e2[k] = shr_zero(e2[k], s);
		end
		cr[0] = e1[1]*e2[2] - e1[2]*e2[1];
		cr[1] = e1[2]*e2[0] - e1[0]*e2[2];
		cr[2] = e1[0]*e2[1] - e1[1]*e2[0];
		forever begin
			m = 0;
			for (k = 0; k < 3; k++) if (mag(cr[k]) > m) m = mag(cr[k]);
			if (m == 0) begin
				for (k = 0; k < 3; k++) n[k] = '0;
				return;
			end
			if (m >= (64'd1 << 30)) for (k = 0; k < 3; k++) cr[k] = shr_zero(cr[k], 1);
			else if (m < (64'd1 << 29)) for (k = 0; k < 3; k++) cr[k] = cr[k] * 2;
			else break;
		end
		len = int_sqrt(cr[0]*cr[0] + cr[1]*cr[1] + cr[2]*cr[2]);
		for (k = 0; k < 3; k++) begin
			q = (mag(cr[k]) * 65536 + len / 2) / len;
			n[k] = (cr[k] < 0) ? -q[31:0] : q[31:0];
		end
	endtask

	function automatic res_word_t mk(logic [1:0] kd, logic signed [31:0] x,
			logic signed [31:0] y, logic signed [31:0] z, logic [1:0] cd, logic f);
		res_word_t r;
		r.kind = kd; r.x = x; r.y = y; r.z = z; r.code = cd; r.fin = f;
		return r;
	endfunction

	// append one expected word at the tail
	function automatic void add_expected(res_word_t w);
		pending_q.insert(pending_q.size(), w);
	endfunction

	task automatic predict_word(logic [1:0] rq, logic [1:0] ri, logic signed [31:0] vx,
			logic signed [31:0] vy, logic signed [31:0] vz, logic [15:0] ca,
			logic [15:0] cb, logic [15:0] cc);
		logic signed [31:0] crn [3][3];
		logic signed [31:0] nrm [3];
		int idx [3];
		int k, j;
		case (rq)
			REQ_CLEAR: vtx_count = 0;
			REQ_APPEND: begin
				if (vtx_count >= DEPTH)
					add_expected(mk(KIND_ERROR, 0, 0, 0, ERR_FULL, 1'b1));
				else begin
					vtx_mem[vtx_count][0] = vx;
					vtx_mem[vtx_count][1] = vy;
					vtx_mem[vtx_count][2] = vz;
					vtx_count++;
				end
			end
			REQ_ROW: begin
				mtx[ri*3] = vx; mtx[ri*3+1] = vy; mtx[ri*3+2] = vz;
			end
			default: begin
				idx[0] = ca; idx[1] = cb; idx[2] = cc;
				for (k = 0; k < 3; k++)
					if (idx[k] >= vtx_count) begin
						add_expected(mk(KIND_ERROR, 0, 0, 0, ERR_INDEX, 1'b1));
						return;
					end
				for (k = 0; k < 3; k++) begin
					for (j = 0; j < 3; j++) crn[k][j] = xform_axis(idx[k], j);
					add_expected(mk(KIND_CORNER, crn[k][0], crn[k][1], crn[k][2],
						ERR_NONE, 1'b0));
				end
				unit_normal(crn, nrm);
				add_expected(mk(KIND_NORMAL, nrm[0], nrm[1], nrm[2], ERR_NONE, 1'b1));
			end
		endcase
	endtask

	// ---------------- checking ----------------
	task automatic report_mismatch(string what, longint got, longint want);
		$display("MISMATCH %s: got %0d want %0d at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	// receiver stall pattern: mostly ready, periodic stall runs, random holes
	int stall_phase = 0;
	always @(posedge clk) begin
		res_word_t w;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_q.size() == 0)
					report_mismatch("unexpected word kind", result_kind, -1);
				else begin
					w = pending_q.pop_front();
					if (result_kind !== w.kind) report_mismatch("result_kind", result_kind, w.kind);
					if (out_x !== w.x) report_mismatch("out_x", out_x, w.x);
					if (out_y !== w.y) report_mismatch("out_y", out_y, w.y);
					if (out_z !== w.z) report_mismatch("out_z", out_z, w.z);
					if (error_code !== w.code) report_mismatch("error_code", error_code, w.code);
					if (last !== w.fin) report_mismatch("last", last, w.fin);
				end
			end
			stall_phase <= (stall_phase + 1) % 97;
			if (stall_phase > 60 && stall_phase < 75)
				out_ready <= 1'b1;
			else if (stall_phase >= 80)
				out_ready <= ($urandom_range(0, 3) == 0);
			else
				out_ready <= ($urandom_range(0, 4) != 0);
		end
	end

	// watchdog on cycles with no accepted word
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("triangle_transform_face_normal_unit: mismatch");
			$finish;
		end
	end

	// ---------------- stimulus ----------------
	task automatic send_word(logic [1:0] rq, logic [1:0] ri, logic signed [31:0] vx,
			logic signed [31:0] vy, logic signed [31:0] vz, logic [15:0] ca = 0,
			logic [15:0] cb = 0, logic [15:0] cc = 0);
		// bursty sender: random gap between bursts
		if (burst_left == 0) begin
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		req_type <= rq; row_index <= ri;
		val_x <= vx; val_y <= vy; val_z <= vz;
		corner_a <= ca; corner_b <= cb; corner_c <= cc;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_word(rq, ri, vx, vy, vz, ca, cb, cc);
		if (burst_left == 0) in_valid <= 1'b0;
	endtask

	task automatic drain;
		if (burst_left != 0) begin
			in_valid <= 1'b0;
			burst_left = 0;
		end
		@(posedge clk);
		while (pending_q.size() != 0) @(posedge clk);
	endtask

	function automatic logic signed [31:0] rnd_val();
		case ($urandom_range(0, 4))
			0: return $urandom;
			1: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
			2: return $signed($urandom_range(0, 32'h7ffffff)) - 32'sh4000000;
			3: return ($urandom_range(0, 1)) ? 32'sh7fffffff : 32'sh80000000;
			default: return $signed($urandom_range(0, 32'h1fffff)) - 32'sh100000;
		endcase
	endfunction

	function automatic logic [15:0] rnd_idx();
		if (vtx_count > 0 && $urandom_range(0, 9) != 0)
			return 16'($urandom_range(0, vtx_count - 1));
		return 16'($urandom);
	endfunction

	task automatic load_matrix(bit ident);
		int r;
		for (r = 0; r < 4; r++)
			if (ident)
				send_word(REQ_ROW, 2'(r), (r == 0) ? 32'sh10000 : 0,
					(r == 1) ? 32'sh10000 : 0, (r == 2) ? 32'sh10000 : 0);
			else if (r == 3)
				send_word(REQ_ROW, 2'(r), rnd_val(), rnd_val(), rnd_val());
			else
				send_word(REQ_ROW, 2'(r), $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000,
					$signed($urandom_range(0, 32'h3ffff)) - 32'sh20000,
					$signed($urandom_range(0, 32'h3ffff)) - 32'sh20000);
	endtask

	task automatic test_directed;
		send_word(REQ_TRI, 0, 0, 0, 0, 0, 0, 0);                 // empty store: bad index
		send_word(REQ_APPEND, 0, 32'sh7fffffff, 32'sh80000000, 0);
		send_word(REQ_APPEND, 0, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff);
		send_word(REQ_APPEND, 0, 32'sh10000, 0, 32'sh80000000);
		send_word(REQ_APPEND, 0, 0, 32'sh10000, 0);
		send_word(REQ_TRI, 0, 0, 0, 0, 0, 1, 2);                 // identity, extreme edges
		send_word(REQ_TRI, 0, 0, 0, 0, 1, 1, 1);                 // degenerate
		send_word(REQ_TRI, 0, 0, 0, 0, 0, 1, 16'hffff);          // bad index
		send_word(REQ_ROW, 3, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
		send_word(REQ_ROW, 0, 32'sh80000000, 32'sh7fffffff, 32'sh80000000);
		send_word(REQ_TRI, 0, 0, 0, 0, 3, 2, 0);                 // saturating corners
		send_word(REQ_CLEAR, 0, 0, 0, 0);
		send_word(REQ_TRI, 0, 0, 0, 0, 0, 0, 0);                 // cleared store
		load_matrix(1'b1);
		drain();
	endtask

	task automatic test_random(int n);
		int i, p;
		logic [15:0] a;
		send_word(REQ_CLEAR, 0, 0, 0, 0);
		for (i = 0; i < n; i++) begin
			p = $urandom_range(0, 99);
			if (i == n / 2) drain();                                 // pause until idle
			if (p < 3) send_word(REQ_CLEAR, 2'($urandom), $urandom, $urandom, $urandom);
			else if (p < 35 || vtx_count < 3)
				send_word(REQ_APPEND, 2'($urandom), rnd_val(), rnd_val(), rnd_val());
			else if (p < 45) send_word(REQ_ROW, 2'($urandom), rnd_val(), rnd_val(), rnd_val());
			else if (p < 48) load_matrix(1'($urandom_range(0, 1)));
			else begin
				a = rnd_idx();
				send_word(REQ_TRI, 2'($urandom), $urandom, $urandom, $urandom, a,
					($urandom_range(0, 15) == 0) ? a : rnd_idx(), rnd_idx());
			end
		end
		drain();
	endtask

	initial begin
		int i;
		for (i = 0; i < 12; i++) mtx[i] = 0;
		mtx[0] = 32'sh10000; mtx[4] = 32'sh10000; mtx[8] = 32'sh10000;
		vtx_count = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(300);
		repeat (300) @(posedge clk);
		if (mismatches == 0 && pending_q.size() == 0)
			$display("triangle_transform_face_normal_unit: match");
		else
			$display("triangle_transform_face_normal_unit: mismatch");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/tfn_pkg.sv
rtl/core/tfn_vstore.sv
rtl/core/tfn_mul.sv
rtl/core/tfn_dsq.sv
rtl/core/triangle_transform_face_normal_unit.sv
verif/tb_top.sv
